// ===== hdl/rccm_pkg.sv =====
// ----------------------------------------------------------------------------
// rccm_pkg : reactance to control-value mapper package
// Widths, register indexes, curve codes and the elaborated threshold tables.
// ----------------------------------------------------------------------------
package rccm_pkg;

   localparam int FULL_SCALE_OHMS = 300;
   localparam int SUB_OHM         = 16;
   localparam int FULL_SCALE      = FULL_SCALE_OHMS * SUB_OHM;
   localparam int LOG_KNEE        = 30 * SUB_OHM;
   localparam int LOG_TOP         = LOG_KNEE * 10;
   localparam int CURVE_STEPS     = 127;
   localparam int CURVE_SQ        = CURVE_STEPS * CURVE_STEPS;
   localparam int IDX_W           = 7;
   localparam int TBL_DEPTH       = 1 << IDX_W;

   localparam int SAMPLE_W   = 20;
   localparam int DZ_W       = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MAG_W = $clog2(((FULL_SCALE > LOG_TOP) ? FULL_SCALE : LOG_TOP) + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_DZ_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DZ_SIZE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_MODE = 2'd2;

   localparam logic [MODE_W-1:0] CURVE_LINEAR = 2'd0;
   localparam logic [MODE_W-1:0] CURVE_LOG    = 2'd1;
   localparam logic [MODE_W-1:0] CURVE_SQUARE = 2'd2;
   localparam logic [MODE_W-1:0] CURVE_SQRT   = 2'd3;

   localparam logic              DZ_ENABLE_RST  = 1'b1;
   localparam logic [DZ_W-1:0]   DZ_SIZE_RST    = 16'd80;
   localparam logic [MODE_W-1:0] CURVE_MODE_RST = CURVE_LINEAR;

   typedef logic [TBL_DEPTH-1:0][MAG_W-1:0] curve_thr_type;
   typedef curve_thr_type [3:0]             thr_table_type;

   typedef struct packed {
      logic [MAG_W-1:0]  mag;
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  idx;
   } search_type;

   // Q60 fixed point
   localparam logic [63:0] Q_ONE    = 64'd1 << 60;
   localparam logic [63:0] Q_HI0    = Q_ONE + Q_ONE / 50;
   localparam logic [63:0] Q_ELEVEN = 64'd11 << 60;

   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic logic [63:0] qpow(input logic [63:0] r);
      logic [63:0] p;
      p = Q_ONE;
      for (int i = 0; i < CURVE_STEPS; i++) begin
         p = qmul(p, r);
      end
      return p;
   endfunction

   function automatic curve_thr_type log_thresholds();
      logic [63:0]   lo;
      logic [63:0]   hi;
      logic [63:0]   mid;
      logic [63:0]   p;
      logic [63:0]   d;
      logic [63:0]   ip;
      logic [63:0]   fr;
      logic [63:0]   prod;
      logic [63:0]   t;
      curve_thr_type thr;
      lo = Q_ONE;
      hi = Q_HI0;
      while (hi - lo > 64'd1) begin
         mid = lo + ((hi - lo) >> 1);
         if (qpow(mid) <= Q_ELEVEN) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      thr = '0;
      p   = Q_ONE;
      for (int k = 1; k <= CURVE_STEPS; k++) begin
         p    = qmul(p, lo);
         d    = p - Q_ONE;
         ip   = d >> 60;
         fr   = (d & (Q_ONE - 64'd1)) >> 12;
         prod = 64'(LOG_KNEE) * fr;
         t    = 64'(LOG_KNEE) * ip + (prod >> 48);
         if (prod[47:0] != 48'd0) begin
            t = t + 64'd1;
         end
         thr[k] = MAG_W'(t);
      end
      return thr;
   endfunction

   function automatic thr_table_type build_thresholds();
      logic [63:0]   t;
      logic [63:0]   target;
      logic [63:0]   m;
      logic [63:0]   c;
      thr_table_type tbl;
      tbl = '0;
      tbl[CURVE_LOG] = log_thresholds();
      for (int k = 1; k <= CURVE_STEPS; k++) begin
         t = (64'(FULL_SCALE) * 64'(k) + 64'(CURVE_STEPS - 1)) / CURVE_STEPS;
         tbl[CURVE_LINEAR][k] = MAG_W'(t);
         t = (64'(FULL_SCALE) * 64'(k) * 64'(k) + 64'(CURVE_SQ - 1)) / CURVE_SQ;
         tbl[CURVE_SQRT][k] = MAG_W'(t);
         // smallest m with 127*m*m >= FS*FS*k
         target = 64'(FULL_SCALE) * 64'(FULL_SCALE) * 64'(k);
         m = 64'd0;
         for (int b = MAG_W - 1; b >= 0; b--) begin
            c = m | (64'd1 << b);
            if (64'(CURVE_STEPS) * c * c < target) begin
               m = c;
            end
         end
         tbl[CURVE_SQUARE][k] = MAG_W'(m + 64'd1);
      end
      return tbl;
   endfunction

   localparam thr_table_type THRESHOLDS = build_thresholds();

endpackage

// ===== hdl/rccm_search.sv =====
// ----------------------------------------------------------------------------
// rccm_search : pipelined threshold search
// One result bit per stage, most significant first, over the curve's table.
// ----------------------------------------------------------------------------
module rccm_search import rccm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  search_type in_stage,
   output logic       out_valid,
   output search_type out_stage
);

   logic [IDX_W-1:0] valid_ff;
   logic [IDX_W-1:0] valid_in;
   search_type       stage_ff [IDX_W];
   search_type       stage_in [IDX_W];
   search_type       src      [IDX_W];

   always_comb begin
      logic [IDX_W-1:0] cand;
      src[0] = in_stage;
      for (int s = 1; s < IDX_W; s++) begin
         src[s] = stage_ff[s-1];
      end
      for (int s = 0; s < IDX_W; s++) begin
         cand        = src[s].idx | (IDX_W'(1) << (IDX_W - 1 - s));
         stage_in[s] = src[s];
         if (THRESHOLDS[src[s].mode][cand] <= src[s].mag) begin
            stage_in[s].idx = cand;
         end
      end
      valid_in = {valid_ff[IDX_W-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff[IDX_W-1];
   assign out_stage = stage_ff[IDX_W-1];

endmodule

// ===== hdl/reactance_to_cc_curve_mapper.sv =====
// ----------------------------------------------------------------------------
// reactance_to_cc_curve_mapper : reactance sample to 7-bit control value
// Magnitude, deadzone and saturation, then a threshold search on the curve.
//
//   channel  ports                          transaction
//   request  start, busy, req_*             start && !busy
//   result   rsp_strobe, rsp_*              rsp_strobe high
//   config   csr_write_enable, csr_*        write enable high
//
// One transaction per cycle; the result passes one magnitude stage and seven
// search stages, one result bit each.
// busy is always low. Synchronous reset clears stage valids and restores
// the registers. The result side takes every strobe, so nothing stalls.
// ----------------------------------------------------------------------------
module reactance_to_cc_curve_mapper import rccm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [SAMPLE_W-1:0]  req_reactance_sample,
   output logic                        rsp_strobe,
   output logic        [IDX_W-1:0]     rsp_control_value,
   input  logic                        csr_write_enable,
   input  logic        [CSR_IDX_W-1:0] csr_index,
   input  logic        [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [SAMPLE_W-1:0] FULL_SCALE_S = SAMPLE_W'(FULL_SCALE);

   logic              dz_enable_ff;
   logic [DZ_W-1:0]   dz_size_ff;
   logic [MODE_W-1:0] curve_mode_ff;

   logic              entry_valid_ff;
   search_type        entry_ff;
   search_type        entry_in;

   logic [SAMPLE_W-1:0] sample_u;
   logic [SAMPLE_W-1:0] mag_raw;
   logic                dead;
   logic                accept;

   search_type          result;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_enable_ff  <= DZ_ENABLE_RST;
         dz_size_ff    <= DZ_SIZE_RST;
         curve_mode_ff <= CURVE_MODE_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DZ_ENABLE:  dz_enable_ff  <= csr_wdata[0];
            CSR_DZ_SIZE:    dz_size_ff    <= csr_wdata[DZ_W-1:0];
            CSR_CURVE_MODE: curve_mode_ff <= csr_wdata[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sample_u = req_reactance_sample;
      mag_raw  = sample_u[SAMPLE_W-1] ? (~sample_u + SAMPLE_W'(1)) : sample_u;
      dead     = dz_enable_ff && (mag_raw < {{(SAMPLE_W-DZ_W){1'b0}}, dz_size_ff});
      entry_in.mode = curve_mode_ff;
      entry_in.idx  = '0;
      // zero magnitude maps to zero on every curve
      if (dead) begin
         entry_in.mag = '0;
      end else if (mag_raw > FULL_SCALE_S) begin
         entry_in.mag = MAG_W'(FULL_SCALE);
      end else begin
         entry_in.mag = mag_raw[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   rccm_search u_search (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (entry_valid_ff),
      .in_stage  (entry_ff),
      .out_valid (rsp_strobe),
      .out_stage (result)
   );

   assign rsp_control_value = result.idx;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : testbench for reactance_to_cc_curve_mapper
// Drives reactance samples and register writes. Every control value is
// checked against an in-bench model of deadzone, saturation and the four
// curves. Directed cases are followed by randomised phases, most with random gaps.
// ----------------------------------------------------------------------------
module tb_top;
   import rccm_pkg::*;

   localparam int          CC_STEPS    = 127;
   localparam int          KNEE_UNITS  = 480;
   localparam longint      FS_UNITS    = longint'(FULL_SCALE_OHMS) * 16;
   localparam int          STALL_LIMIT = 1000;
   localparam int          DRAIN_WAIT  = 16;
   localparam int          PHASES      = 12;
   localparam int          PHASE_ITEMS = 155;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [63:0] FX_ONE = 64'd1 << 60;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic [IDX_W-1:0]           value;
   } cc_expect_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic signed [SAMPLE_W-1:0]   req_reactance_sample = '0;
   logic                         rsp_strobe;
   logic [IDX_W-1:0]             rsp_control_value;
   logic                         csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   logic                         cfg_dz_enable = 1'b1;
   logic [DZ_W-1:0]              cfg_dz_size   = 16'd80;
   logic [MODE_W-1:0]            cfg_curve     = CURVE_LINEAR;

   longint unsigned              log_step [1:CC_STEPS];
   cc_expect_type                cc_expected [$];
   cc_expect_type                cc_head;
   int                           fail_count  = 0;
   int                           stall_count = 0;

   reactance_to_cc_curve_mapper DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_reactance_sample (req_reactance_sample),
      .rsp_strobe           (rsp_strobe),
      .rsp_control_value    (rsp_control_value),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Q60 product, truncated to 64 bits
   function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] w;
      w = 128'(a) * 128'(b);
      return 64'(w >> 60);
   endfunction

   function automatic logic [63:0] fx_pow127(input logic [63:0] r);
      logic [63:0] acc;
      acc = FX_ONE;
      repeat (CC_STEPS) acc = fx_mul(acc, r);
      return acc;
   endfunction

   // log curve thresholds: ceil(480 * (r^k - 1)), r^127 just below 11
   task automatic build_log_steps();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] pw;
      logic [63:0] frac;
      lo = FX_ONE;
      hi = FX_ONE + FX_ONE / 64'd50;
      while (hi - lo > 64'd1) begin
         mid = lo + (hi - lo) / 64'd2;
         if (fx_pow127(mid) <= 64'd11 * FX_ONE) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      pw = FX_ONE;
      for (int k = 1; k <= CC_STEPS; k++) begin
         pw   = fx_mul(pw, lo);
         frac = 64'(KNEE_UNITS) * ((pw - FX_ONE) >> 12);
         log_step[k] = (frac + ((64'd1 << 48) - 64'd1)) >> 48;
      end
   endtask

   function automatic logic [IDX_W-1:0] map_reactance(input logic signed [SAMPLE_W-1:0] x);
      longint sx;
      longint unsigned mag;
      longint unsigned v;
      sx  = x;
      mag = (sx < 0) ? longint'(-sx) : longint'(sx);
      v   = 0;
      if (cfg_dz_enable && mag < longint'(cfg_dz_size)) return '0;
      if (mag > FS_UNITS) mag = FS_UNITS;
      case (cfg_curve)
         CURVE_LINEAR: v = (127 * mag) / FS_UNITS;
         CURVE_LOG: begin
            for (int k = 1; k <= CC_STEPS; k++) if (mag >= log_step[k]) v = k;
         end
         CURVE_SQUARE: v = (127 * mag * mag) / (FS_UNITS * FS_UNITS);
         default: begin
            for (int k = 1; k <= CC_STEPS; k++) begin
               if (longint'(k) * k * FS_UNITS <= 16129 * mag) v = k;
            end
         end
      endcase
      if (v > 127) v = 127;
      return IDX_W'(v);
   endfunction

   function automatic int pick_gap(input bit idle_ok);
      int r;
      if (!idle_ok) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int  kind;
      int  k;
      int  mag;
      real frac;
      real base;
      kind = $urandom_range(0, 19);
      if (kind < 9) begin
         mag = $urandom_range(0, 4900);
      end else if (kind < 11) begin
         mag = int'(cfg_dz_size) + int'($urandom_range(0, 4)) - 2;
      end else if (kind < 15) begin
         k    = $urandom_range(1, CC_STEPS);
         frac = real'(k) / 127.0;
         case (cfg_curve)
            CURVE_LINEAR: base = real'(FS_UNITS) * frac;
            CURVE_SQUARE: base = real'(FS_UNITS) * $sqrt(frac);
            CURVE_SQRT:   base = real'(FS_UNITS) * frac * frac;
            default:      base = real'(log_step[k]);
         endcase
         mag = $rtoi(base) + int'($urandom_range(0, 6)) - 3;
      end else if (kind < 17) begin
         return SAMPLE_W'($urandom);
      end else if (kind == 17) begin
         mag = $urandom_range(0, 100);
      end else begin
         case ($urandom_range(0, 3))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       mag = int'(FS_UNITS);
            default: mag = 0;
         endcase
      end
      if (mag < 0) mag = 0;
      return ($urandom_range(0, 1) != 0) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit idle_ok);
      int gap;
      gap = pick_gap(idle_ok);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                <= 1'b1;
      req_reactance_sample <= s;
      do @(posedge clock); while (busy !== 1'b0);
      cc_expected.push_back('{s, map_reactance(s)});
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (cc_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      case (idx)
         CSR_DZ_ENABLE:  cfg_dz_enable = data[0];
         CSR_DZ_SIZE:    cfg_dz_size   = data[DZ_W-1:0];
         CSR_CURVE_MODE: cfg_curve     = data[MODE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // upper bits of the narrow registers carry junk
   task automatic apply_config(input logic en, input logic [DZ_W-1:0] size,
                               input logic [MODE_W-1:0] mode);
      logic [CSR_DATA_W-1:0] data;
      wait_idle();
      data    = CSR_DATA_W'($urandom);
      data[0] = en;
      write_csr(CSR_DZ_ENABLE, data);
      write_csr(CSR_DZ_SIZE, size);
      data              = CSR_DATA_W'($urandom);
      data[MODE_W-1:0]  = mode;
      write_csr(CSR_CURVE_MODE, data);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_reset_values();
      send_sample(20'sd0, 1'b1);
      send_sample(20'sd79, 1'b1);
      send_sample(-20'sd80, 1'b1);
      send_sample(20'sd80, 1'b1);
   endtask

   task automatic test_sample_extremes();
      apply_config(1'b0, 16'd80, CURVE_LINEAR);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(20'sd4801, 1'b1);
      send_sample(-20'sd1, 1'b1);
   endtask

   task automatic test_curve_shapes();
      apply_config(1'b0, 16'd0, CURVE_LOG);
      send_sample(20'sd480, 1'b1);
      send_sample(20'sd4800, 1'b1);
      send_sample(-20'sd4799, 1'b1);
      apply_config(1'b0, 16'd0, CURVE_SQUARE);
      send_sample(20'sd2400, 1'b1);
      send_sample(-20'sd4799, 1'b1);
      apply_config(1'b0, 16'd0, CURVE_SQRT);
      send_sample(20'sd1, 1'b1);
      send_sample(20'sd300, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1);
   endtask

   // compare is on the magnitude before saturation
   task automatic test_deadzone_limits();
      apply_config(1'b1, 16'hFFFF, CURVE_SQRT);
      send_sample(20'sd65534, 1'b1);
      send_sample(-20'sd65535, 1'b1);
      apply_config(1'b1, 16'd0, CURVE_LINEAR);
      send_sample(20'sd0, 1'b1);
   endtask

   task automatic test_unused_index();
      apply_config(1'b0, 16'd0, CURVE_LINEAR);
      @(posedge clock);
      write_csr(CSR_UNUSED, '1);
      csr_write_enable <= 1'b0;
      send_sample(20'sd2400, 1'b1);
   endtask

   task automatic test_random_stream();
      logic              en;
      logic [DZ_W-1:0]   size;
      logic [MODE_W-1:0] mode;
      bit                idle_ok;
      for (int p = 0; p < PHASES; p++) begin
         mode = MODE_W'(p % 4);
         en   = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 5))
            0:       size = '0;
            1:       size = '1;
            2, 3:    size = DZ_W'($urandom_range(0, 600));
            4:       size = DZ_W'($urandom);
            default: size = DZ_W'($urandom_range(4000, 5000));
         endcase
         if (p == 2) begin
            en   = 1'b1;
            size = '1;
         end
         if (p == 3) size = '0;
         apply_config(en, size, mode);
         idle_ok = (p % 3 != 1);
         repeat (PHASE_ITEMS) send_sample(pick_sample(), idle_ok);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (cc_expected.size() == 0) begin
            $error("rsp_control_value: unexpected transaction, actual %0d", rsp_control_value);
            fail_count++;
         end else begin
            cc_head = cc_expected.pop_front();
            if (rsp_control_value !== cc_head.value) begin
               $error("rsp_control_value: expected %0d, actual %0d (sample %0d)",
                      cc_head.value, rsp_control_value, cc_head.sample);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      build_log_steps();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_sample_extremes();
      test_curve_shapes();
      test_deadzone_limits();
      test_unused_index();
      test_random_stream();
      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rccm_pkg.sv
hdl/rccm_search.sv
hdl/reactance_to_cc_curve_mapper.sv
verif/tb_top.sv
